### hdl/segment_sphere_collision_unit_defines.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef SEGMENT_SPHERE_COLLISION_UNIT_DEFINES_SVH
`define SEGMENT_SPHERE_COLLISION_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssc check failed");
// implication whose consequent is checked in the following cycle
`define SSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssc check failed");
`endif

### hdl/ssc_pkg.sv
// shared constants and types for the segment sphere collision unit
// no dependencies
package ssc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CRD_W = 32;
  localparam int DIF_W = 33;
  localparam int PRD_W = 66;
  localparam int SUM_W = 68;
  localparam int T_W = FRAC_BITS;

  typedef enum logic [1:0] {
    REGION_START = 2'd0,
    REGION_INNER = 2'd1,
    REGION_END   = 2'd2
  } region_t;

  typedef enum logic [2:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5
  } reg_index_t;
endpackage

### hdl/segment_sphere_collision_unit.sv
// segment sphere collision unit: pipelined closest point and hit test
// depends on ssc_pkg
//
// channels: s_axis carries one sphere per transaction (centre and radius),
// m_axis carries one result per sphere (hit, closest point, region).
// cfg writes the segment endpoints by register index 0..5; write only
// while no transaction is in flight.
// the pipeline depth is set by the restoring divider, one quotient bit
// per stage. throughput: one transaction per cycle while the output
// stage is empty or being taken; every stage holds a valid bit.
// reset clears the endpoint registers and all valid bits.
// when the output stage is full and m_axis_tready is low the whole
// pipeline holds; s_axis_tready is high whenever the output stage is
// empty or being taken, and bubbles inside the pipeline stay where they are.
module segment_sphere_collision_unit
  import ssc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_x, center_y, center_z, radius, zero fill
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit, near_x, near_y, near_z, region, zero fill
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  localparam int NDIV = T_W;
  localparam int NST = NDIV + 8;

  logic signed [CRD_W-1:0] sx, sy, sz, ex, ey, ez;
  logic adv;
  logic [NST-1:0] vld;

  assign cfg_ready = 1'b1;
  assign adv = ~vld[NST-1] | m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0; sy <= '0; sz <= '0; ex <= '0; ey <= '0; ez <= '0;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_START_X: sx <= cfg_data;
        REG_START_Y: sy <= cfg_data;
        REG_START_Z: sz <= cfg_data;
        REG_END_X:   ex <= cfg_data;
        REG_END_Y:   ey <= cfg_data;
        REG_END_Z:   ez <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NST-2:0], s_axis_tvalid};
  end

  // stage 1: differences
  logic signed [DIF_W-1:0] a_dx, a_dy, a_dz, a_px, a_py, a_pz;
  logic signed [CRD_W-1:0] a_cx, a_cy, a_cz;
  logic [30:0] a_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx <= DIF_W'(ex) - DIF_W'(sx);
      a_dy <= DIF_W'(ey) - DIF_W'(sy);
      a_dz <= DIF_W'(ez) - DIF_W'(sz);
      a_px <= DIF_W'($signed(s_axis_tdata[31:0])) - DIF_W'(sx);
      a_py <= DIF_W'($signed(s_axis_tdata[63:32])) - DIF_W'(sy);
      a_pz <= DIF_W'($signed(s_axis_tdata[95:64])) - DIF_W'(sz);
      a_cx <= s_axis_tdata[31:0];
      a_cy <= s_axis_tdata[63:32];
      a_cz <= s_axis_tdata[95:64];
      a_r  <= s_axis_tdata[126:96];
    end
  end

  // stage 2: products
  logic signed [PRD_W-1:0] b_n0, b_n1, b_n2, b_d0, b_d1, b_d2;
  logic signed [DIF_W-1:0] b_dx, b_dy, b_dz;
  logic signed [CRD_W-1:0] b_cx, b_cy, b_cz;
  logic [30:0] b_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      b_n0 <= PRD_W'(a_dx) * PRD_W'(a_px);
      b_n1 <= PRD_W'(a_dy) * PRD_W'(a_py);
      b_n2 <= PRD_W'(a_dz) * PRD_W'(a_pz);
      b_d0 <= PRD_W'(a_dx) * PRD_W'(a_dx);
      b_d1 <= PRD_W'(a_dy) * PRD_W'(a_dy);
      b_d2 <= PRD_W'(a_dz) * PRD_W'(a_dz);
      b_dx <= a_dx; b_dy <= a_dy; b_dz <= a_dz;
      b_cx <= a_cx; b_cy <= a_cy; b_cz <= a_cz; b_r <= a_r;
    end
  end

  // stage 3: sums and region
  logic signed [SUM_W-1:0] c_num, c_den, nsum, dsum;
  logic [1:0] c_reg;
  logic signed [DIF_W-1:0] c_dx, c_dy, c_dz;
  logic signed [CRD_W-1:0] c_cx, c_cy, c_cz;
  logic [30:0] c_r;
  always_comb begin
    nsum = SUM_W'(b_n0) + SUM_W'(b_n1) + SUM_W'(b_n2);
    dsum = SUM_W'(b_d0) + SUM_W'(b_d1) + SUM_W'(b_d2);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_num <= nsum;
      c_den <= dsum;
      if (dsum == '0 || nsum <= 0) c_reg <= REGION_START;
      else if (nsum >= dsum) c_reg <= REGION_END;
      else c_reg <= REGION_INNER;
      c_dx <= b_dx; c_dy <= b_dy; c_dz <= b_dz;
      c_cx <= b_cx; c_cy <= b_cy; c_cz <= b_cz; c_r <= b_r;
    end
  end

  // divider stages: one quotient bit each
  logic [SUM_W-1:0] q_rem [NDIV+1];
  logic [SUM_W-1:0] q_den [NDIV+1];
  logic [T_W-1:0]   q_t   [NDIV+1];
  logic [1:0]       q_reg [NDIV+1];
  logic signed [DIF_W-1:0] q_dx [NDIV+1], q_dy [NDIV+1], q_dz [NDIV+1];
  logic signed [CRD_W-1:0] q_cx [NDIV+1], q_cy [NDIV+1], q_cz [NDIV+1];
  logic [30:0] q_r [NDIV+1];

  always_comb begin
    q_rem[0] = (c_reg == REGION_INNER) ? c_num : '0;
    q_den[0] = c_den; q_t[0] = '0; q_reg[0] = c_reg;
    q_dx[0] = c_dx; q_dy[0] = c_dy; q_dz[0] = c_dz;
    q_cx[0] = c_cx; q_cy[0] = c_cy; q_cz[0] = c_cz; q_r[0] = c_r;
  end

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    logic [SUM_W:0] sh;
    logic [SUM_W:0] df;
    always_comb begin
      sh = {q_rem[g], 1'b0};
      df = sh - {1'b0, q_den[g]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!df[SUM_W]) begin
          q_rem[g+1] <= df[SUM_W-1:0];
          q_t[g+1] <= {q_t[g][T_W-2:0], 1'b1};
        end else begin
          q_rem[g+1] <= sh[SUM_W-1:0];
          q_t[g+1] <= {q_t[g][T_W-2:0], 1'b0};
        end
        q_den[g+1] <= q_den[g]; q_reg[g+1] <= q_reg[g];
        q_dx[g+1] <= q_dx[g]; q_dy[g+1] <= q_dy[g]; q_dz[g+1] <= q_dz[g];
        q_cx[g+1] <= q_cx[g]; q_cy[g+1] <= q_cy[g]; q_cz[g+1] <= q_cz[g];
        q_r[g+1] <= q_r[g];
      end
    end
  end

  // lerp multiply: t * d, floor shift
  localparam int LP_W = DIF_W + T_W + 1;
  logic signed [LP_W-1:0] l_px, l_py, l_pz;
  logic [1:0] l_reg;
  logic signed [CRD_W-1:0] l_cx, l_cy, l_cz;
  logic [30:0] l_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      l_px <= LP_W'($signed({1'b0, q_t[NDIV]})) * LP_W'(q_dx[NDIV]);
      l_py <= LP_W'($signed({1'b0, q_t[NDIV]})) * LP_W'(q_dy[NDIV]);
      l_pz <= LP_W'($signed({1'b0, q_t[NDIV]})) * LP_W'(q_dz[NDIV]);
      l_reg <= q_reg[NDIV];
      l_cx <= q_cx[NDIV]; l_cy <= q_cy[NDIV]; l_cz <= q_cz[NDIV];
      l_r <= q_r[NDIV];
    end
  end

  // closest point
  logic signed [CRD_W-1:0] n_x, n_y, n_z, qx, qy, qz;
  logic [1:0] n_reg;
  logic signed [CRD_W-1:0] n_cx, n_cy, n_cz;
  logic [30:0] n_r;
  always_comb begin
    case (region_t'(l_reg))
      REGION_END: begin qx = ex; qy = ey; qz = ez; end
      REGION_INNER: begin
        qx = sx + CRD_W'(l_px >>> FRAC_BITS);
        qy = sy + CRD_W'(l_py >>> FRAC_BITS);
        qz = sz + CRD_W'(l_pz >>> FRAC_BITS);
      end
      default: begin qx = sx; qy = sy; qz = sz; end
    endcase
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      n_x <= qx; n_y <= qy; n_z <= qz; n_reg <= l_reg;
      n_cx <= l_cx; n_cy <= l_cy; n_cz <= l_cz; n_r <= l_r;
    end
  end

  // offsets
  logic signed [DIF_W-1:0] o_x, o_y, o_z;
  logic signed [CRD_W-1:0] o_nx, o_ny, o_nz;
  logic [1:0] o_reg;
  logic [30:0] o_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      o_x <= DIF_W'(n_cx) - DIF_W'(n_x);
      o_y <= DIF_W'(n_cy) - DIF_W'(n_y);
      o_z <= DIF_W'(n_cz) - DIF_W'(n_z);
      o_nx <= n_x; o_ny <= n_y; o_nz <= n_z; o_reg <= n_reg; o_r <= n_r;
    end
  end

  // squares
  logic [PRD_W-1:0] s_x2, s_y2, s_z2;
  logic [61:0] s_rr;
  logic signed [CRD_W-1:0] s_nx, s_ny, s_nz;
  logic [1:0] s_reg;
  always_ff @(posedge clk) begin
    if (adv) begin
      s_x2 <= PRD_W'(PRD_W'(o_x) * PRD_W'(o_x));
      s_y2 <= PRD_W'(PRD_W'(o_y) * PRD_W'(o_y));
      s_z2 <= PRD_W'(PRD_W'(o_z) * PRD_W'(o_z));
      s_rr <= 62'(o_r) * 62'(o_r);
      s_nx <= o_nx; s_ny <= o_ny; s_nz <= o_nz; s_reg <= o_reg;
    end
  end

  // compare and output register
  logic [SUM_W-1:0] dsq;
  assign dsq = SUM_W'(s_x2) + SUM_W'(s_y2) + SUM_W'(s_z2);
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {5'd0, s_reg, s_nz, s_ny, s_nx,
                       (SUM_W'(s_rr) >= dsq)};
    end
  end
endmodule

### hdl/ssc_checker.sv
// port-level checker for the segment sphere collision unit
// depends on segment_sphere_collision_unit_defines.svh
`include "segment_sphere_collision_unit_defines.svh"
module ssc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);
  `SSC_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `SSC_ASSERT_IMP(a_region_code, m_axis_tvalid, m_axis_tdata[98:97] != 2'd3)
  `SSC_ASSERT_IMP(a_ready_free, !m_axis_tvalid, s_axis_tready)
  `SSC_ASSERT_IMP(a_stall_block, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind segment_sphere_collision_unit ssc_checker u_ssc_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
